// File: hw/rtl/slbfw_pkg.sv
// ----------------------------------------------------------------------------
// slbfw_pkg
// Shared types and constants of the status LED blink/flash WS2812 unit.
// ----------------------------------------------------------------------------
package slbfw_pkg;

    // Command codes carried on the mode field
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_STEADY = 2'd1,
        MODE_BLINK  = 2'd2,
        MODE_FLASH  = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BRIGHTNESS_SHIFT = 3'd0,
        CFG_ZERO_HIGH        = 3'd1,
        CFG_ONE_HIGH         = 3'd2,
        CFG_BIT_PERIOD       = 3'd3,
        CFG_LATCH_GAP        = 3'd4
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned SHIFT_W      = 3;
    localparam int unsigned COLOR_W      = 24;
    localparam int unsigned FRAME_BITS   = 24;
    localparam int unsigned BIT_CNT_W    = 5;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX = BIT_CNT_W'(FRAME_BITS - 1);
    localparam logic [SHIFT_W-1:0]   BRIGHTNESS_RST = 3'd2;

    typedef logic [COLOR_W-1:0] t_color;

    // 0xRRGGBB in, scaled G,R,B frame out (G in the top byte)
    function automatic t_color build_frame(input t_color color,
                                           input logic [SHIFT_W-1:0] sh);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = color[23:16] >> sh;
        g = color[15:8]  >> sh;
        b = color[7:0]   >> sh;
        return {g, r, b};
    endfunction

endpackage

// File: hw/rtl/status_led_blink_flash_ws2812_unit.sv
// ----------------------------------------------------------------------------
// status_led_blink_flash_ws2812_unit
// Steady / blink / flash colour control for one WS2812 LED, frame serializer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries ticks (mode 0, one per
//   millisecond) and colour commands (steady, blink, flash). Every command
//   and every tick that changes the LED produces one 24-bit GRB frame,
//   scaled by the brightness shift, sent MSB first on the output channel
//   (o_out_valid / i_out_stall) as one bit per transfer; o_last_bit marks
//   the 24th bit. A tick that changes nothing produces no transfer.
//   An item is registered at its accepting edge, evaluated once the
//   serializer is free, and its first bit is valid once its frame is loaded.
//   Throughput: one item per cycle while no frame is in flight; an item
//   that produces a frame occupies the serializer for 24 output transfers,
//   so the frame shift register sets the rate. The input register holds
//   one further item meanwhile.
//   An output stall freezes the serializer and, once the input register is
//   full, backs up into o_in_stall.
//   Reset (synchronous, active low) clears the LED state to off, no blink,
//   no flash, brightness shift 2, and empties both registers.
//   Config writes take effect at once; only the brightness shift changes
//   the frames, the line timing registers belong to the pulse generator.
// ----------------------------------------------------------------------------
module status_led_blink_flash_ws2812_unit #(
    parameter int unsigned TIME_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  slbfw_pkg::t_mode            i_mode,
    input  logic [23:0]                 i_color,
    input  logic [15:0]                 i_time_ms,
    // frame bit channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_data_bit,
    output logic                        o_last_bit,
    // configuration write port
    input  logic                        i_cfg_we,
    input  slbfw_pkg::t_cfg_idx         i_cfg_index,
    input  logic [slbfw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import slbfw_pkg::*;

    // input register
    logic                 r_in_valid;
    t_mode                r_mode;
    t_color               r_color;
    logic [15:0]          r_time_ms;

    // LED state
    t_color               r_shown, n_shown;
    t_color               r_saved, n_saved;
    logic [TIME_BITS-1:0] r_blink_period, n_blink_period;
    logic [TIME_BITS-1:0] r_blink_elapsed, n_blink_elapsed;
    logic                 r_phase_on, n_phase_on;
    logic                 r_flash_on, n_flash_on;
    logic [TIME_BITS-1:0] r_flash_left, n_flash_left;

    logic [SHIFT_W-1:0]   r_bright_sh;

    // serializer
    logic                 r_busy;
    t_color               r_shift;
    logic [BIT_CNT_W-1:0] r_cnt;

    logic                 w_in_xfer;
    logic                 w_out_xfer;
    logic                 w_last;
    logic                 w_proc;
    logic                 w_emit;
    t_color               w_emit_color;
    logic [TIME_BITS-1:0] w_time;
    logic [TIME_BITS-1:0] w_elapsed_inc;

    assign w_last      = (r_cnt == LAST_BIT_IDX);
    assign w_out_xfer  = r_busy & ~i_out_stall;
    // evaluate the held item once the serializer is free or frees this cycle
    assign w_proc      = r_in_valid & (~r_busy | (w_out_xfer & w_last));
    assign o_in_stall  = r_in_valid & ~w_proc;
    assign w_in_xfer   = i_in_valid & ~o_in_stall;

    assign o_out_valid = r_busy;
    assign o_data_bit  = r_shift[COLOR_W-1];
    assign o_last_bit  = w_last;

    // duration taken modulo 2^TIME_BITS
    assign w_time        = TIME_BITS'(32'(r_time_ms));
    assign w_elapsed_inc = (r_blink_elapsed != '1) ? r_blink_elapsed + 1'b1
                                                   : r_blink_elapsed;

    // command / tick evaluation
    always_comb begin
        n_shown         = r_shown;
        n_saved         = r_saved;
        n_blink_period  = r_blink_period;
        n_blink_elapsed = r_blink_elapsed;
        n_phase_on      = r_phase_on;
        n_flash_on      = r_flash_on;
        n_flash_left    = r_flash_left;
        w_emit          = 1'b0;
        w_emit_color    = r_color;
        case (r_mode)
            MODE_TICK: begin
                n_blink_elapsed = w_elapsed_inc;
                if (r_flash_on) begin
                    if (r_flash_left <= TIME_BITS'(1)) begin
                        // flash over: restore the commanded colour
                        n_flash_on   = 1'b0;
                        n_flash_left = '0;
                        w_emit       = 1'b1;
                        w_emit_color = r_saved;
                    end else begin
                        n_flash_left = r_flash_left - 1'b1;
                    end
                end else if (r_blink_period != '0 &&
                             w_elapsed_inc >= r_blink_period) begin
                    n_blink_elapsed = '0;
                    n_phase_on      = ~r_phase_on;
                    w_emit          = 1'b1;
                    w_emit_color    = r_phase_on ? '0 : r_shown;
                end
            end
            MODE_STEADY: begin
                n_shown        = r_color;
                n_blink_period = '0;
                w_emit         = 1'b1;
            end
            MODE_BLINK: begin
                n_shown         = r_color;
                n_blink_period  = w_time;
                n_phase_on      = 1'b1;
                n_blink_elapsed = '0;
                w_emit          = 1'b1;
            end
            MODE_FLASH: begin
                n_saved      = r_shown;
                n_flash_on   = 1'b1;
                n_flash_left = w_time;
                w_emit       = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_xfer | (r_in_valid & ~w_proc);
        end
        if (w_in_xfer) begin
            r_mode    <= i_mode;
            r_color   <= i_color;
            r_time_ms <= i_time_ms;
        end
    end

    // LED state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown         <= '0;
            r_saved         <= '0;
            r_blink_period  <= '0;
            r_blink_elapsed <= '0;
            r_phase_on      <= 1'b0;
            r_flash_on      <= 1'b0;
            r_flash_left    <= '0;
            r_bright_sh     <= BRIGHTNESS_RST;
        end else begin
            if (w_proc) begin
                r_shown         <= n_shown;
                r_saved         <= n_saved;
                r_blink_period  <= n_blink_period;
                r_blink_elapsed <= n_blink_elapsed;
                r_phase_on      <= n_phase_on;
                r_flash_on      <= n_flash_on;
                r_flash_left    <= n_flash_left;
            end
            // timing registers are consumed by the line pulse generator
            if (i_cfg_we && i_cfg_index == CFG_BRIGHTNESS_SHIFT) begin
                r_bright_sh <= i_cfg_data[SHIFT_W-1:0];
            end
        end
    end

    // frame serializer, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_proc && w_emit) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_out_xfer) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_proc && w_emit) begin
            r_shift <= build_frame(w_emit_color, r_bright_sh);
        end else if (w_out_xfer) begin
            r_shift <= {r_shift[COLOR_W-2:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= LAST_BIT_IDX)
        else $error("bit counter past end of frame");

    a_flash_left_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_flash_on |-> r_flash_left == '0)
        else $error("flash time left while no flash runs");

    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && w_last && !w_proc) |=> !r_busy)
        else $error("serializer busy after last bit");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_busy))
        else $error("input stalled with serializer free");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_emit) |=> (r_busy && r_cnt == '0))
        else $error("frame not started after emitting item");

endmodule

// File: bench/status_led_blink_flash_ws2812_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// status_led_blink_flash_ws2812_unit_test
// Self-checking bench for the WS2812 status LED unit. Commands and ms ticks
// go in through a valid/stall channel. A local model of the LED state
// (steady, blink, flash with restore) predicts every GRB frame bit, and each
// output transfer is checked in order. A directed table runs first, then
// three random phases with different idle mixes and register settings.
// ----------------------------------------------------------------------------
module status_led_blink_flash_ws2812_unit_test;
    import slbfw_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned SETTLE_CYC   = 8;     // accept, evaluate, first bit
    localparam int unsigned DRAIN_CYC    = 50;
    localparam int unsigned PHASE_ITEMS  = 26;
    localparam int unsigned DIR_ROWS     = 24;
    localparam logic [15:0] TIME_SAT     = 16'hFFFF;

    // one directed row; known rows carry their frame, others use the model
    typedef struct packed {
        t_mode       mode;
        t_color      color;
        logic [15:0] t_ms;
        logic        known;
        logic        has_frame;
        t_color      frame;
    } t_dir_row;

    typedef struct packed {
        logic data;
        logic last;
    } t_bit_due;

    typedef struct {
        logic [2:0]  shift;
        logic [9:0]  zero_high;
        logic [9:0]  one_high;
        logic [10:0] bit_period;
        logic [15:0] latch_gap;
    } t_led_cfg;

    // reset state is checked against the typed-in frames (shift 2)
    localparam t_dir_row DIRECTED_ROWS [DIR_ROWS] = '{
        '{MODE_TICK,   24'h000000, 16'h0000, 1'b1, 1'b0, 24'h000000},
        '{MODE_STEADY, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1, 24'h3F3F3F},
        '{MODE_STEADY, 24'h000000, 16'h0000, 1'b1, 1'b1, 24'h000000},
        '{MODE_STEADY, 24'hFF0000, 16'h0000, 1'b1, 1'b1, 24'h003F00},
        '{MODE_STEADY, 24'h00FF00, 16'h0000, 1'b1, 1'b1, 24'h3F0000},
        '{MODE_STEADY, 24'h0000FF, 16'h0000, 1'b1, 1'b1, 24'h00003F},
        // blink, interval 2: off, then on again
        '{MODE_BLINK,  24'h123456, 16'h0002, 1'b0, 1'b0, 24'h000000},
        '{MODE_TICK,   24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0, 24'h000000},
        '{MODE_TICK,   24'h000000, 16'h0000, 1'b0, 1'b0, 24'h000000},
        '{MODE_TICK,   24'h000000, 16'h0000, 1'b0, 1'b0, 24'h000000},
        '{MODE_TICK,   24'h000000, 16'h0000, 1'b0, 1'b0, 24'h000000},
        // zero interval means steady
        '{MODE_BLINK,  24'hABCDEF, 16'h0000, 1'b0, 1'b0, 24'h000000},
        '{MODE_TICK,   24'h000000, 16'h0000, 1'b0, 1'b0, 24'h000000},
        // zero duration flash ends on the next tick
        '{MODE_FLASH,  24'h00FF00, 16'h0000, 1'b0, 1'b0, 24'h000000},
        '{MODE_TICK,   24'h000000, 16'h0000, 1'b0, 1'b0, 24'h000000},
        // blink under flash, steady under flash, flash restarting a flash
        '{MODE_BLINK,  24'h5A96C3, 16'h0003, 1'b0, 1'b0, 24'h000000},
        '{MODE_FLASH,  24'hFFFFFF, 16'h0003, 1'b0, 1'b0, 24'h000000},
        '{MODE_TICK,   24'h000000, 16'h0000, 1'b0, 1'b0, 24'h000000},
        '{MODE_TICK,   24'h000000, 16'h0000, 1'b0, 1'b0, 24'h000000},
        '{MODE_STEADY, 24'h808080, 16'h0000, 1'b0, 1'b0, 24'h000000},
        '{MODE_FLASH,  24'h010203, 16'h0002, 1'b0, 1'b0, 24'h000000},
        '{MODE_TICK,   24'h000000, 16'h0000, 1'b0, 1'b0, 24'h000000},
        '{MODE_TICK,   24'h000000, 16'h0000, 1'b0, 1'b0, 24'h000000},
        '{MODE_STEADY, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1, 24'h3F3F3F}
    };

    localparam t_cfg_idx CFG_ORDER [5] = '{
        CFG_BRIGHTNESS_SHIFT, CFG_ZERO_HIGH, CFG_ONE_HIGH, CFG_BIT_PERIOD, CFG_LATCH_GAP
    };

    // DUT connections, inputs all known from time zero
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    t_mode                  i_mode      = MODE_TICK;
    logic [23:0]            i_color     = '0;
    logic [15:0]            i_time_ms   = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_data_bit;
    logic                   o_last_bit;
    logic                   i_cfg_we    = 1'b0;
    t_cfg_idx               i_cfg_index = CFG_BRIGHTNESS_SHIFT;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // LED state model, reset values
    t_color      led_shown     = '0;
    t_color      led_saved     = '0;
    logic [15:0] blink_period  = '0;
    logic [15:0] blink_elapsed = '0;
    logic        blink_on      = 1'b0;
    logic        flash_active  = 1'b0;
    logic [15:0] flash_left    = '0;
    t_led_cfg    cfg_shadow    = '{3'd2, 10'd40, 10'd80, 11'd125, 16'd5000};

    t_bit_due    frame_bits_due [$];
    t_bit_due    due_bit;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count   = 0;
    int unsigned errors        = 0;

    status_led_blink_flash_ws2812_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_color     (i_color),
        .i_time_ms   (i_time_ms),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_bit  (o_data_bit),
        .o_last_bit  (o_last_bit),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance the LED model by one item; reports whether a frame goes out.
    task automatic advance_led(input t_mode mode, input t_color color,
                               input logic [15:0] t_ms,
                               output logic has_frame, output t_color frame);
        t_color src;
        has_frame = 1'b0;
        src       = '0;
        case (mode)
            MODE_TICK: begin
                // elapsed keeps counting under a flash, saturating
                if (blink_elapsed != TIME_SAT)
                    blink_elapsed = blink_elapsed + 16'd1;
                if (flash_active) begin
                    if (flash_left <= 16'd1) begin
                        flash_active = 1'b0;
                        flash_left   = '0;
                        src          = led_saved;
                        has_frame    = 1'b1;
                    end else begin
                        flash_left = flash_left - 16'd1;
                    end
                end else if (blink_period != 16'd0 && blink_elapsed >= blink_period) begin
                    blink_elapsed = '0;
                    blink_on      = !blink_on;
                    src           = blink_on ? led_shown : '0;
                    has_frame     = 1'b1;
                end
            end
            MODE_STEADY: begin
                led_shown    = color;
                blink_period = '0;
                src          = color;
                has_frame    = 1'b1;
            end
            MODE_BLINK: begin
                led_shown     = color;
                blink_period  = t_ms;
                blink_on      = 1'b1;
                blink_elapsed = '0;
                src           = color;
                has_frame     = 1'b1;
            end
            default: begin
                led_saved    = led_shown;
                flash_active = 1'b1;
                flash_left   = t_ms;
                src          = color;
                has_frame    = 1'b1;
            end
        endcase
        // G, R, B, each channel scaled by the brightness shift
        frame = {src[15:8] >> cfg_shadow.shift, src[23:16] >> cfg_shadow.shift,
                 src[7:0] >> cfg_shadow.shift};
    endtask

    // Offer one item, wait for its transfer, queue its frame bits.
    // Entered and left just after a rising edge.
    task automatic send_cmd(input t_mode mode, input t_color color,
                            input logic [15:0] t_ms, input logic use_known,
                            input logic known_has, input t_color known_frame);
        logic   has_frame;
        t_color frame;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_color    <= color;
        i_time_ms  <= t_ms;
        do @(posedge i_clk); while (o_in_stall);
        advance_led(mode, color, t_ms, has_frame, frame);
        if (use_known) begin
            has_frame = known_has;
            frame     = known_frame;
        end
        if (has_frame)
            for (int k = 23; k >= 0; k--)
                frame_bits_due.push_back('{frame[k], k == 0});
    endtask

    // Drop valid, wait until every frame bit is out plus a short margin
    // for a tick that may still be in flight.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (frame_bits_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write all five registers back to back, one per edge.
    task automatic load_config(input logic [2:0] shift, input logic [9:0] zero_high,
                               input logic [9:0] one_high, input logic [10:0] bit_period,
                               input logic [15:0] latch_gap);
        logic [CFG_DATA_W-1:0] vals [5];
        vals = '{16'(shift), 16'(zero_high), 16'(one_high), 16'(bit_period), latch_gap};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_ORDER[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we              <= 1'b0;
        cfg_shadow.shift      = shift;
        cfg_shadow.zero_high  = zero_high;
        cfg_shadow.one_high   = one_high;
        cfg_shadow.bit_period = bit_period;
        cfg_shadow.latch_gap  = latch_gap;
    endtask

    // Mostly ticks with short intervals so blinks toggle and flashes end;
    // now and then a long or full-range time.
    task automatic run_random(input int unsigned count);
        int unsigned pick;
        int unsigned tsel;
        t_mode       mode;
        logic [15:0] t_ms;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            tsel = $urandom_range(99);
            if (pick < 58)      mode = MODE_TICK;
            else if (pick < 68) mode = MODE_STEADY;
            else if (pick < 83) mode = MODE_BLINK;
            else                mode = MODE_FLASH;
            if (tsel < 80)      t_ms = 16'($urandom_range(0, 6));
            else if (tsel < 95) t_ms = 16'($urandom_range(7, 40));
            else                t_ms = 16'($urandom());
            send_cmd(mode, t_color'($urandom()), t_ms, 1'b0, 1'b0, '0);
        end
    endtask

    // Output side: random stall, in-order check of every bit transfer,
    // and the run timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("[status_led_blink_flash_ws2812_unit] ERROR");
            $finish;
        end else begin
            i_out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (frame_bits_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected transfer: expected none, got data_bit %0b last_bit %0b",
                             $time, o_data_bit, o_last_bit);
                end else begin
                    due_bit = frame_bits_due.pop_front();
                    if (o_data_bit !== due_bit.data) begin
                        errors++;
                        $display("%0t data_bit mismatch: expected %0b, got %0b",
                                 $time, due_bit.data, o_data_bit);
                    end
                    if (o_last_bit !== due_bit.last) begin
                        errors++;
                        $display("%0t last_bit mismatch: expected %0b, got %0b",
                                 $time, due_bit.last, o_last_bit);
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows at reset register values
        for (int r = 0; r < DIR_ROWS; r++)
            send_cmd(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].color, DIRECTED_ROWS[r].t_ms,
                     DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].has_frame,
                     DIRECTED_ROWS[r].frame);
        settle();

        // phase 1: sparse sender, busy receiver, full brightness, fastest timing
        load_config(3'd0, 10'd1, 10'd1, 11'd2, 16'd1);
        send_idle_pct = 28;
        recv_idle_pct = 72;
        run_random(PHASE_ITEMS);
        settle();

        // phase 2: the other way round, dimmest shift, slowest timing
        load_config(3'd7, 10'd1023, 10'd1023, 11'd2047, 16'd65535);
        send_idle_pct = 72;
        recv_idle_pct = 28;
        run_random(PHASE_ITEMS);
        settle();

        // phase 3: back to back, mid-range settings
        load_config(3'($urandom_range(1, 6)), 10'($urandom_range(1, 1023)),
                    10'($urandom_range(1, 1023)), 11'($urandom_range(2, 2047)),
                    16'($urandom_range(1, 65535)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        settle();

        repeat (DRAIN_CYC) @(posedge i_clk);
        if (frame_bits_due.size() != 0) begin
            errors++;
            $display("%0t missing transfers: expected %0d more frame bits, got none",
                     $time, frame_bits_due.size());
        end
        if (errors == 0)
            $display("[status_led_blink_flash_ws2812_unit] OK");
        else
            $display("[status_led_blink_flash_ws2812_unit] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/slbfw_pkg.sv
hw/rtl/status_led_blink_flash_ws2812_unit.sv
bench/status_led_blink_flash_ws2812_unit_test.sv
